// ===== hdl/mtba_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mtba_pkg
// Shared types, constants and helpers of the masked trapezoid block average.
// ============================================================================
package mtba_pkg;

    localparam int MAX_CELL_WIDTH_DEF  = 64;
    localparam int MAX_CELL_LAYERS_DEF = 64;

    localparam int SIZE_W      = 7;
    localparam int VALUE_W     = 32;
    localparam int STEP_W      = 31;
    localparam int MARGIN_W    = 16;
    localparam int INDEX_W     = 12;
    localparam int OFFSET_W    = 6;
    localparam int SUM_W       = 64;
    localparam int WEIGHT_W    = 22;
    localparam int PROD_W      = INDEX_W + STEP_W;
    localparam int DEPTH_W     = PROD_W + 2;
    localparam int DIV_STEPS   = SUM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int IN_DATA_W   = 128;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 3;

    localparam logic [SIZE_W-1:0]    CELL_WIDTH_RST    = 7'd4;
    localparam logic [SIZE_W-1:0]    CELL_LAYERS_RST   = 7'd4;
    localparam logic [VALUE_W-1:0]   DEPTH_ORIGIN_RST  = 32'd0;
    localparam logic [STEP_W-1:0]    DEPTH_STEP_RST    = 31'd65536;
    localparam logic [MARGIN_W-1:0]  BOTTOM_MARGIN_RST = 16'd1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CELL_WIDTH    = 3'd0,
        REG_CELL_LAYERS   = 3'd1,
        REG_DEPTH_ORIGIN  = 3'd2,
        REG_DEPTH_STEP    = 3'd3,
        REG_BOTTOM_MARGIN = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [SIZE_W-1:0]          cell_width;
        logic [SIZE_W-1:0]          cell_layers;
        logic signed [VALUE_W-1:0]  depth_origin;
        logic [STEP_W-1:0]          depth_step;
        logic [MARGIN_W-1:0]        bottom_margin;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic accum;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic div_last;
        logic out_free;
    } dp_stat_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [8:0] maxv);
        logic [SIZE_W-1:0] res;
        if (v < 7'd2)
        begin
            res = 7'd2;
        end
        else if ({2'b00, v} > maxv)
        begin
            res = maxv[SIZE_W-1:0];
        end
        else
        begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== hdl/mtba_cfg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mtba_cfg
// Configuration register file with an APB-style access port.
// ============================================================================
module mtba_cfg
    import mtba_pkg::*;
#(
    parameter int MAX_CELL_WIDTH  = MAX_CELL_WIDTH_DEF,
    parameter int MAX_CELL_LAYERS = MAX_CELL_LAYERS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t           cfg_reg;
    logic           wr_en;
    reg_idx_t       idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_width    <= CELL_WIDTH_RST;
            cfg_reg.cell_layers   <= CELL_LAYERS_RST;
            cfg_reg.depth_origin  <= DEPTH_ORIGIN_RST;
            cfg_reg.depth_step    <= DEPTH_STEP_RST;
            cfg_reg.bottom_margin <= BOTTOM_MARGIN_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_CELL_WIDTH:
                    cfg_reg.cell_width <= clamp_size(pwdata[SIZE_W-1:0],
                                                     9'(MAX_CELL_WIDTH));
                REG_CELL_LAYERS:
                    cfg_reg.cell_layers <= clamp_size(pwdata[SIZE_W-1:0],
                                                      9'(MAX_CELL_LAYERS));
                REG_DEPTH_ORIGIN:  cfg_reg.depth_origin  <= pwdata;
                REG_DEPTH_STEP:    cfg_reg.depth_step    <= pwdata[STEP_W-1:0];
                REG_BOTTOM_MARGIN: cfg_reg.bottom_margin <= pwdata[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CELL_WIDTH:    prdata = {25'd0, cfg_reg.cell_width};
            REG_CELL_LAYERS:   prdata = {25'd0, cfg_reg.cell_layers};
            REG_DEPTH_ORIGIN:  prdata = cfg_reg.depth_origin;
            REG_DEPTH_STEP:    prdata = {1'b0, cfg_reg.depth_step};
            REG_BOTTOM_MARGIN: prdata = {16'd0, cfg_reg.bottom_margin};
            default:           prdata = '0;
        endcase
    end

endmodule

// ===== hdl/mtba_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mtba_ctrl
// Sequencer for sample capture, accumulation, division and result hand-off.
// ============================================================================
module mtba_ctrl
    import mtba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ACC  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = stat.last ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.load_out = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/mtba_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mtba_dp
// Depth test, trapezoid weighting, accumulators, bit-serial divider and
// output register.
// ============================================================================
module mtba_dp
    import mtba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [VALUE_W-1:0]   m_tdata,
    output logic                 m_tuser
);

    logic [VALUE_W-1:0]  val_reg;
    logic                nodata_reg;
    logic [VALUE_W-1:0]  top_reg;
    logic [VALUE_W-1:0]  bot_reg;
    logic [OFFSET_W-1:0] ox_reg;
    logic [OFFSET_W-1:0] oy_reg;
    logic [OFFSET_W-1:0] oz_reg;
    logic                last_reg;
    logic [PROD_W-1:0]   prod_reg;

    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [WEIGHT_W-1:0] wsum_reg;
    logic [WEIGHT_W-1:0] wsum_next;

    logic [SUM_W-1:0]    dvd_reg;
    logic [WEIGHT_W-1:0] rem_reg;
    logic [WEIGHT_W-1:0] div_w_reg;
    logic                neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_data_reg;
    logic                out_nodata_reg;

    logic signed [DEPTH_W-1:0] depth;
    logic signed [DEPTH_W-1:0] limit;
    logic                in_layer;
    logic                face_x;
    logic                face_y;
    logic                face_z;
    logic [1:0]          faces;
    logic [1:0]          shamt;
    logic [SUM_W-1:0]    term;
    logic                take;
    logic                div_init;
    logic [SUM_W-1:0]    mag;
    logic [WEIGHT_W:0]   trial;
    logic                ge;
    logic [WEIGHT_W:0]   rem_dbl;
    logic [SUM_W:0]      quot;
    logic [VALUE_W-1:0]  avg;

    // Depth of the sample against the layer between top and bottom minus margin.
    assign depth  = DEPTH_W'($signed(cfg.depth_origin)) + $signed({2'b00, prod_reg});
    assign limit  = DEPTH_W'($signed(bot_reg)) - $signed({{(DEPTH_W-MARGIN_W){1'b0}},
                                                         cfg.bottom_margin});
    assign in_layer = (depth >= DEPTH_W'($signed(top_reg))) && (depth < limit);

    assign face_x = (ox_reg == '0) || ({1'b0, ox_reg} == cfg.cell_width - 7'd1);
    assign face_y = (oy_reg == '0) || ({1'b0, oy_reg} == cfg.cell_width - 7'd1);
    assign face_z = (oz_reg == '0) || ({1'b0, oz_reg} == cfg.cell_layers - 7'd1);
    assign faces  = 2'(face_x) + 2'(face_y) + 2'(face_z);
    assign shamt  = 2'd3 - faces;
    assign term   = SUM_W'($signed(val_reg)) << shamt;
    assign take   = !nodata_reg && in_layer;

    assign sum_next  = take ? sum_reg + term : sum_reg;
    assign wsum_next = take ? wsum_reg + (WEIGHT_W'(4'd8) >> faces) : wsum_reg;
    assign div_init  = cmd.accum && last_reg;
    assign mag       = sum_next[SUM_W-1] ? (SUM_W'(0) - sum_next) : sum_next;

    assign trial = {rem_reg, dvd_reg[SUM_W-1]};
    assign ge    = trial >= {1'b0, div_w_reg};

    // Round half away from zero on the magnitude, then saturate.
    assign rem_dbl = {rem_reg, 1'b0};
    assign quot    = {1'b0, dvd_reg} + (SUM_W+1)'(rem_dbl >= {1'b0, div_w_reg});

    always_comb
    begin
        if (neg_reg)
        begin
            if (quot > (SUM_W+1)'(33'h080000000))
            begin
                avg = 32'h80000000;
            end
            else
            begin
                avg = 32'd0 - quot[VALUE_W-1:0];
            end
        end
        else if (quot > (SUM_W+1)'(32'h7FFFFFFF))
        begin
            avg = 32'h7FFFFFFF;
        end
        else
        begin
            avg = quot[VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            val_reg    <= s_tdata[31:0];
            nodata_reg <= s_tuser;
            top_reg    <= s_tdata[63:32];
            bot_reg    <= s_tdata[95:64];
            ox_reg     <= s_tdata[113:108];
            oy_reg     <= s_tdata[119:114];
            oz_reg     <= s_tdata[125:120];
            last_reg   <= s_tlast;
            prod_reg   <= s_tdata[107:96] * cfg.depth_step;
        end
        if (div_init)
        begin
            dvd_reg   <= mag;
            rem_reg   <= '0;
            div_w_reg <= wsum_next;
            neg_reg   <= sum_next[SUM_W-1];
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[SUM_W-2:0], ge};
            rem_reg <= ge ? WEIGHT_W'(trial - {1'b0, div_w_reg}) : trial[WEIGHT_W-1:0];
        end
        if (cmd.load_out)
        begin
            out_nodata_reg <= (div_w_reg == '0);
            out_data_reg   <= (div_w_reg == '0) ? '0 : avg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            wsum_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accum)
            begin
                sum_reg  <= last_reg ? '0 : sum_next;
                wsum_reg <= last_reg ? '0 : wsum_next;
            end
            if (div_init)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.last     = last_reg;
    assign stat.div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_nodata_reg;

endmodule

// ===== hdl/masked_trapezoid_block_average.sv =====
`timescale 1ns / 1ps
// ============================================================================
// masked_trapezoid_block_average
// Trapezoid-weighted mean of the valid fine samples of one coarse cell.
// ============================================================================
// Samples of one coarse cell enter on the s_ stream, one word each, with
// s_tlast on the final sample. A sample is taken when it is not flagged
// no-data in s_tuser and its depth lies inside the layer; it is weighted
// by one half for every cell face it sits on and accumulated.
// Each sample passes a capture cycle holding the depth multiply and an
// accumulate cycle holding the depth compare and the adders. The final
// sample then runs a one-bit-per-cycle restoring divider, and a last step
// rounds and loads the output register once it is free; m_tuser flags a
// cell with no valid sample, and then m_tdata is zero.
// The output register holds a result until m_tready; meanwhile samples of
// the next cell are taken, and only a second finished cell waits for it.
// Reset clears the accumulators and the output valid and loads the
// register defaults. Configuration is written over the APB port; the user
// is to write it only while idle, as the block itself does not enforce it.
// ============================================================================
module masked_trapezoid_block_average
    import mtba_pkg::*;
#(
    parameter int MAX_CELL_WIDTH  = MAX_CELL_WIDTH_DEF,
    parameter int MAX_CELL_LAYERS = MAX_CELL_LAYERS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // sample_value, surface_top, surface_bottom, depth_index, offset_x,
    // offset_y, offset_z, zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // sample_no_data
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // cell_average
    output logic [VALUE_W-1:0]    m_tdata,
    // cell_no_data
    output logic                  m_tuser
);

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    mtba_cfg #(
        .MAX_CELL_WIDTH  (MAX_CELL_WIDTH),
        .MAX_CELL_LAYERS (MAX_CELL_LAYERS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mtba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mtba_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== hdl/mtba_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mtba_checker
// Port-level checks of the block average, bound to the top level.
// ============================================================================
module mtba_checker
    import mtba_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [VALUE_W-1:0] m_tdata,
    input logic               m_tuser
);

    // A result word that is not taken stays unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A cell without valid samples reports a zero average.
    a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("no-data result carries a nonzero average");

    // Every sample occupies the block for its accumulate cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample accepted in consecutive cycles");

    // No result can appear in the cycle right after a sample is taken.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared right after a sample");

endmodule

bind masked_trapezoid_block_average mtba_checker u_mtba_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== test/masked_trapezoid_block_average_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// masked_trapezoid_block_average_tb
// Self-checking testbench of the masked trapezoid block average.
// ============================================================================
// Streams the samples of coarse cells into the block and compares every
// result word with a cell-level predictor kept in a small scoreboard class.
// A short directed set at the reset defaults comes first: extreme values,
// no-data and out-of-layer samples, exact layer boundaries, rounding ties
// and every face count. Phases of random cells follow under several
// register settings, extremes and clamped sizes included, with sender
// gaps, receiver stalls and one long receiver hold that backs up the input.
// ============================================================================
module masked_trapezoid_block_average_tb;
    import mtba_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 80;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_SAMPLES  = 175;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic signed [31:0]   LAYER_BOT  = 32'sd6553600;

    typedef struct {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      sample_no_data;
        logic signed [VALUE_W-1:0] surface_top;
        logic signed [VALUE_W-1:0] surface_bottom;
        logic [INDEX_W-1:0]        depth_index;
        logic [OFFSET_W-1:0]       offset_x;
        logic [OFFSET_W-1:0]       offset_y;
        logic [OFFSET_W-1:0]       offset_z;
        logic                      last_of_cell;
    } sample_t;

    typedef struct {
        logic signed [VALUE_W-1:0] cell_average;
        logic                      cell_no_data;
    } cell_result_t;

    class cell_average_scoreboard;
        logic [SIZE_W-1:0]         cell_width;
        logic [SIZE_W-1:0]         cell_layers;
        logic signed [VALUE_W-1:0] depth_origin;
        logic [STEP_W-1:0]         depth_step;
        logic [MARGIN_W-1:0]       bottom_margin;
        logic [SUM_W-1:0]          weighted_sum;
        logic [WEIGHT_W-1:0]       weight_eighths;
        cell_result_t              expected_q[$];
        int                        errors;
        int                        samples;
        int                        cells;
        int                        empty_cells;

        function new();
            cell_width     = CELL_WIDTH_RST;
            cell_layers    = CELL_LAYERS_RST;
            depth_origin   = DEPTH_ORIGIN_RST;
            depth_step     = DEPTH_STEP_RST;
            bottom_margin  = BOTTOM_MARGIN_RST;
            weighted_sum   = '0;
            weight_eighths = '0;
            errors         = 0;
            samples        = 0;
            cells          = 0;
            empty_cells    = 0;
        endfunction

        function logic [SIZE_W-1:0] fit_size(logic [SIZE_W-1:0] v, int top_size);
            if (v < 7'd2)
                return 7'd2;
            if (int'(v) > top_size)
                return SIZE_W'(top_size);
            return v;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_CELL_WIDTH:    cell_width    = fit_size(data[6:0], MAX_CELL_WIDTH_DEF);
                REG_CELL_LAYERS:   cell_layers   = fit_size(data[6:0], MAX_CELL_LAYERS_DEF);
                REG_DEPTH_ORIGIN:  depth_origin  = data;
                REG_DEPTH_STEP:    depth_step    = data[30:0];
                REG_BOTTOM_MARGIN: bottom_margin = data[15:0];
                default:           ;
            endcase
        endfunction

        function int on_face(logic [OFFSET_W-1:0] off, logic [SIZE_W-1:0] size);
            return (int'(off) == 0 || int'(off) == int'(size) - 1) ? 1 : 0;
        endfunction

        function void close_cell();
            cell_result_t res;
            logic [63:0]  mag;
            logic [63:0]  quo;
            logic [63:0]  rem;
            logic [63:0]  divisor;
            if (weight_eighths == '0)
            begin
                res.cell_average = '0;
                res.cell_no_data = 1'b1;
                empty_cells++;
            end
            else
            begin
                divisor = 64'(weight_eighths);
                mag = weighted_sum[63] ? (64'd0 - weighted_sum) : weighted_sum;
                quo = mag / divisor;
                rem = mag % divisor;
                if (rem >= divisor - rem)
                    quo = quo + 64'd1;
                if (weighted_sum[63])
                begin
                    if (quo > 64'h8000_0000)
                        quo = 64'h8000_0000;
                    quo = 64'd0 - quo;
                end
                else if (quo > 64'h7FFF_FFFF)
                begin
                    quo = 64'h7FFF_FFFF;
                end
                res.cell_average = quo[31:0];
                res.cell_no_data = 1'b0;
            end
            expected_q.push_back(res);
            cells++;
            weighted_sum   = '0;
            weight_eighths = '0;
        endfunction

        function void note_sample(sample_t smp);
            longint depth;
            longint floor_depth;
            longint value_ext;
            int     faces;
            int     weight;
            depth = longint'(depth_origin)
                  + longint'(smp.depth_index) * longint'(depth_step);
            floor_depth = longint'(smp.surface_bottom) - longint'(bottom_margin);
            samples++;
            if (!smp.sample_no_data && depth >= longint'(smp.surface_top)
                && depth < floor_depth)
            begin
                faces = on_face(smp.offset_x, cell_width) + on_face(smp.offset_y, cell_width)
                      + on_face(smp.offset_z, cell_layers);
                weight = 8 >> faces;
                value_ext = longint'(smp.sample_value);
                weighted_sum = weighted_sum + 64'(value_ext * weight);
                weight_eighths = weight_eighths + WEIGHT_W'(weight);
            end
            if (smp.last_of_cell)
                close_cell();
        endfunction

        function void check_result(logic [VALUE_W-1:0] avg, logic no_data);
            cell_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("cell result with no cell pending: cell_average %0d, cell_no_data %0b",
                       $signed(avg), no_data);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (avg !== want.cell_average)
                begin
                    $error("cell_average: expected %0d, actual %0d",
                           want.cell_average, $signed(avg));
                    errors++;
                end
                if (no_data !== want.cell_no_data)
                begin
                    $error("cell_no_data: expected %0b, actual %0b", want.cell_no_data, no_data);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [VALUE_W-1:0]    m_tdata;
    logic                  m_tuser;

    cell_average_scoreboard sb = new();

    int src_idle_pct   = 0;
    int rx_stall_pct   = 0;
    int hold_req       = 0;
    int hold_ack       = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int settings_used  = 1;

    masked_trapezoid_block_average u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_ack != hold_req)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_req;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic sample_t sample_of(logic signed [31:0] value, int no_data,
                                          logic signed [31:0] top, logic signed [31:0] bot,
                                          int idx, int ox, int oy, int oz, int last);
        sample_t smp;
        smp.sample_value   = value;
        smp.sample_no_data = (no_data != 0);
        smp.surface_top    = top;
        smp.surface_bottom = bot;
        smp.depth_index    = INDEX_W'(idx);
        smp.offset_x       = OFFSET_W'(ox);
        smp.offset_y       = OFFSET_W'(oy);
        smp.offset_z       = OFFSET_W'(oz);
        smp.last_of_cell   = (last != 0);
        return smp;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return 32'(v);
    endfunction

    function automatic logic signed [31:0] random_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return 32'sh7FFF_FFFF;
        if (pick < 16)
            return 32'sh8000_0000;
        if (pick < 35)
            return int'($urandom_range(2000)) - 1000;
        return $urandom();
    endfunction

    function automatic logic [OFFSET_W-1:0] random_offset(int size);
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            return '0;
        if (pick < 55)
            return OFFSET_W'(size - 1);
        if (pick < 88)
            return OFFSET_W'($urandom_range(size - 1));
        return OFFSET_W'($urandom_range(63));
    endfunction

    function automatic sample_t random_sample(logic last);
        sample_t smp;
        longint  depth;
        longint  span;
        int      pick;
        pick = $urandom_range(99);
        if (pick < 30)
            smp.depth_index = INDEX_W'($urandom_range(3));
        else if (pick < 75)
            smp.depth_index = INDEX_W'($urandom_range(63));
        else
            smp.depth_index = INDEX_W'($urandom_range(4095));
        depth = longint'(sb.depth_origin)
              + longint'(smp.depth_index) * longint'(sb.depth_step);
        span = longint'($urandom_range(1000000));
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            smp.surface_top    = clip32(depth - span);
            smp.surface_bottom = clip32(depth + sb.bottom_margin + 1 + longint'($urandom_range(1000000)));
        end
        else if (pick < 68)
        begin
            smp.surface_top    = clip32(depth);
            smp.surface_bottom = clip32(depth + sb.bottom_margin + 1);
        end
        else if (pick < 76)
        begin
            smp.surface_top    = clip32(depth - 5);
            smp.surface_bottom = clip32(depth + sb.bottom_margin);
        end
        else if (pick < 88)
        begin
            smp.surface_top    = clip32(depth + 1 + span);
            smp.surface_bottom = 32'sh7FFF_FFFF;
        end
        else
        begin
            smp.surface_top    = $urandom();
            smp.surface_bottom = $urandom();
        end
        smp.sample_value   = random_value();
        smp.sample_no_data = ($urandom_range(99) < 12);
        smp.offset_x       = random_offset(sb.cell_width);
        smp.offset_y       = random_offset(sb.cell_width);
        smp.offset_z       = random_offset(sb.cell_layers);
        smp.last_of_cell   = last;
        return smp;
    endfunction

    task automatic send_sample(input sample_t smp);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, smp.offset_z, smp.offset_y, smp.offset_x, smp.depth_index,
                     smp.surface_bottom, smp.surface_top, smp.sample_value};
        s_tuser  <= smp.sample_no_data;
        s_tlast  <= smp.last_of_cell;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sb.note_sample(smp);
    endtask

    task automatic send_random_cell(input int max_len);
        int len;
        len = $urandom_range(1, max_len);
        for (int i = 0; i < len; i++)
            send_sample(random_sample(i == len - 1));
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        sb.write_reg(idx, data);
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_directed();
        send_sample(sample_of(32'sh7FFF_FFFF, 0, 0, LAYER_BOT, 5, 1, 1, 1, 1));
        send_sample(sample_of(32'sh8000_0000, 0, 0, LAYER_BOT, 5, 0, 0, 0, 1));
        send_sample(sample_of(1234, 1, 0, LAYER_BOT, 5, 1, 1, 1, 1));
        send_sample(sample_of(99, 0, 32'sd655360, LAYER_BOT, 5, 1, 1, 1, 1));
        // Depth equal to bottom minus margin is out, depth equal to top is in.
        send_sample(sample_of(500, 0, 0, 32'sd327681, 5, 1, 1, 1, 0));
        send_sample(sample_of(7, 0, 32'sd327680, LAYER_BOT, 5, 3, 1, 1, 1));
        // Means of exactly one half round away from zero.
        send_sample(sample_of(1, 0, 0, LAYER_BOT, 2, 1, 1, 1, 0));
        send_sample(sample_of(0, 0, 0, LAYER_BOT, 2, 2, 2, 2, 1));
        send_sample(sample_of(-1, 0, 0, LAYER_BOT, 2, 1, 1, 1, 0));
        send_sample(sample_of(0, 0, 0, LAYER_BOT, 2, 2, 2, 2, 1));
        // Zero to three faces, then an offset past the cell edge.
        send_sample(sample_of(8, 0, 0, LAYER_BOT, 3, 1, 1, 1, 0));
        send_sample(sample_of(16, 0, 0, LAYER_BOT, 3, 0, 1, 1, 0));
        send_sample(sample_of(-24, 0, 0, LAYER_BOT, 3, 0, 3, 1, 0));
        send_sample(sample_of(40, 0, 0, LAYER_BOT, 3, 3, 0, 3, 0));
        send_sample(sample_of(100, 0, 0, LAYER_BOT, 3, 63, 63, 63, 1));
        send_sample(sample_of(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 4095,
                              63, 0, 3, 0));
        send_sample(sample_of(32'sh8000_0000, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0,
                              0, 63, 0, 1));
        send_sample(sample_of(555, 1, 0, LAYER_BOT, 4, 1, 2, 1, 0));
        send_sample(sample_of(-3000, 0, 0, LAYER_BOT, 4, 2, 1, 2, 1));
    endtask

    task automatic run_phase(input logic [6:0] width_w, input logic [6:0] layers_w,
                             input logic [31:0] origin_w, input logic [30:0] step_w,
                             input logic [15:0] margin_w, input int gap_pct,
                             input int stall_pct, input int n_samples, input int squeeze);
        int start_count;
        write_reg(REG_CELL_WIDTH, {25'd0, width_w});
        write_reg(REG_CELL_LAYERS, {25'd0, layers_w});
        write_reg(REG_DEPTH_ORIGIN, origin_w);
        write_reg(REG_DEPTH_STEP, {1'b0, step_w});
        write_reg(REG_BOTTOM_MARGIN, {16'd0, margin_w});
        write_reg(REG_UNUSED, $urandom());
        apb_release();
        settings_used++;
        src_idle_pct = gap_pct;
        rx_stall_pct <= stall_pct;
        start_count = sb.samples;
        if (squeeze != 0)
        begin
            hold_req <= hold_req + 1;
            repeat (30) send_random_cell(2);
        end
        while (sb.samples - start_count < n_samples)
            send_random_cell(($urandom_range(9) == 0) ? 40 : 10);
        drain();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        drain();
        run_phase(7'd2, 7'd2, 32'd0, 31'd65536, 16'd1, 0, 0, PHASE_SAMPLES, 0);
        run_phase(7'd127, 7'd100, 32'h8000_0000, 31'h7FFF_FFFF, 16'hFFFF, 68, 0,
                  PHASE_SAMPLES, 0);
        run_phase(7'd0, 7'd1, 32'h7FFF_FFFF, 31'd1, 16'd0, 0, 68, 60, 0);
        run_phase(7'd64, 7'd64, 32'hFC18_0000, 31'd32768, 16'd3, 37, 37, PHASE_SAMPLES, 0);
        run_phase(7'd3, 7'd5, $urandom(), 31'($urandom_range(1, 1 << 20)),
                  16'($urandom_range(65535)), 0, 0, PHASE_SAMPLES, 1);
        run_phase(7'($urandom_range(2, 8)), 7'($urandom_range(2, 8)), $urandom(),
                  31'($urandom_range(1, 32'h7FFF_FFFF)), 16'($urandom_range(65535)), 68, 0,
                  PHASE_SAMPLES, 0);
        run_phase(7'($urandom_range(2, 8)), 7'($urandom_range(2, 8)), $urandom(),
                  31'($urandom_range(1, 1 << 18)), 16'($urandom_range(65535)), 0, 68,
                  PHASE_SAMPLES, 0);
        run_phase(7'($urandom_range(2, 8)), 7'($urandom_range(2, 8)), $urandom(),
                  31'($urandom_range(1, 1 << 18)), 16'($urandom_range(65535)), 37, 37,
                  PHASE_SAMPLES, 0);
        $display("Checked %0d cell results (%0d with no valid sample) from %0d samples",
                 sb.cells, sb.empty_cells, sb.samples);
        $display("over %0d register settings, with gaps, stalls and one long output hold.",
                 settings_used);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
